>>> rtl/fnpm_pkg.sv
// Shared types and constants of the four-neighbour peak marker.
// Used by fnpm_line_store and four_neighbour_peak_marker; depends on nothing.

package fnpm_pkg;

  // Parameter defaults
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned PixelBitsDef = 8;

  // Fixed port widths
  localparam int unsigned PixPortW  = 8;
  localparam int unsigned RowW      = 16;
  localparam int unsigned OutColW   = 10;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned FrameWidW = 11;
  localparam int unsigned CfgIdxW   = 1;

  // Reset values of the frame registers
  localparam int unsigned FrameWidthRst  = 1024;
  localparam int unsigned FrameHeightRst = 1024;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // Line store strobes
  typedef struct packed {
    logic rd_en;     // read both rows at the accepted column
    logic wr_above;  // write the accepted pixel into the row above
    logic wr_two;    // move the old centre into the row two above
  } ls_ctrl_t;

endpackage

>>> rtl/fnpm_line_store.sv
// Two line stores of the peak marker: the row above and the row two above.
// Depends on fnpm_pkg for the strobe struct.

module fnpm_line_store import fnpm_pkg::*; #(
  parameter int unsigned Depth   = MaxWidthDef,
  parameter int unsigned PixBits = PixelBitsDef,
  parameter int unsigned AddrW   = 10
) (
  input  logic               clk_i,
  input  ls_ctrl_t           ctrl_i,
  input  logic [AddrW-1:0]   col_i,
  input  logic [AddrW-1:0]   col_next_i,
  input  logic [PixBits-1:0] pix_i,
  input  logic [AddrW-1:0]   two_addr_i,
  input  logic [PixBits-1:0] two_data_i,
  output logic [PixBits-1:0] centre_o,
  output logic [PixBits-1:0] right_o,
  output logic [PixBits-1:0] up_o
);

  logic [PixBits-1:0] above_mem [Depth];
  logic [PixBits-1:0] two_mem   [Depth];

  logic [PixBits-1:0] centre_q;
  logic [PixBits-1:0] right_q;
  logic [PixBits-1:0] up_q;

  // Read-first: a read and a write at one address in one cycle return old data.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      centre_q <= above_mem[col_i];
      right_q  <= above_mem[col_next_i];
    end
    if (ctrl_i.wr_above) begin
      above_mem[col_i] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      up_q <= two_mem[col_i];
    end
    if (ctrl_i.wr_two) begin
      two_mem[two_addr_i] <= two_data_i;
    end
  end

  assign centre_o = centre_q;
  assign right_o  = right_q;
  assign up_o     = up_q;

endmodule

>>> rtl/four_neighbour_peak_marker.sv
// Four-neighbour strict peak marker, top level.
// Depends on fnpm_pkg and fnpm_line_store.

// Takes a raster-order pixel stream and reports, one word per pixel, whether
// the pixel one row above the current input is strictly greater than its up,
// down, left and right neighbours; border pixels are never flagged. During the
// last row of a multi-row frame each input also reports itself, so those
// inputs produce two words. Pixels enter at one per clock while in_stall_o
// is low; on the last row the single output port, two words per pixel, slows
// the input. Words pass line store read, compare and output register in turn.
// Writing frame_width or frame_height restarts the frame at row 0, column 0;
// write them only while no words are in flight. The line stores are not
// cleared; every used read hits an entry written earlier in that frame.

module four_neighbour_peak_marker import fnpm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Pixel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixPortW-1:0] pixel_i,
  // Result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RowW-1:0]     out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic [PixPortW-1:0] value_o,
  output logic                is_peak_o,
  output logic                last_o
);

  localparam int unsigned ColW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WidCalcW  = 17;
  localparam int unsigned RstWidth  = (MAX_WIDTH < FrameWidthRst) ? MAX_WIDTH
                                                                   : FrameWidthRst;
  localparam logic [ColW-1:0] LastColRst = ColW'(RstWidth - 1);
  localparam logic [RowW-1:0] LastRowRst = RowW'(FrameHeightRst - 1);

  // ---------------------------------------------------------------------------
  // Frame geometry, kept as last column and last row indexes
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] last_col_q;
  logic [RowW-1:0] last_row_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;

  logic                cfg_we;
  logic [WidCalcW-1:0] wid_req;
  logic [ColW-1:0]     last_col_cfg;
  logic [RowW-1:0]     last_row_cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Clamp the requested width to 1..MAX_WIDTH, a zero height acts as one row.
  always_comb begin
    wid_req = WidCalcW'(cfg_data_i[FrameWidW-1:0]);
    if (wid_req == '0) begin
      wid_req = WidCalcW'(1);
    end
    if (wid_req > WidCalcW'(MAX_WIDTH)) begin
      wid_req = WidCalcW'(MAX_WIDTH);
    end
    last_col_cfg = ColW'(wid_req - WidCalcW'(1));
    last_row_cfg = (cfg_data_i[RowW-1:0] == '0) ? '0 : cfg_data_i[RowW-1:0] - 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage enables
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q, s2_second_q;
  logic s1_has_up_q, s1_last_row_q;
  logic s2_has_up_q, s2_last_row_q;
  logic in_acc, s1_nores, s1_adv, s1_ready;
  logic s2_final, s2_ready, s2_load, s3_free, s3_load;

  assign s3_free   = !out_valid_q || !out_stall_i;
  assign s3_load   = s2_valid_q && s3_free;
  // Second word is pending only for an item that reports two pixels.
  assign s2_final  = !(s2_has_up_q && s2_last_row_q) || s2_second_q;
  assign s2_ready  = !s2_valid_q || (s3_load && s2_final);
  // First-row words of a multi-row frame produce nothing: drop them at stage 1.
  assign s1_nores  = !s1_has_up_q && !s1_last_row_q;
  assign s1_adv    = s1_valid_q && (s1_nores || s2_ready);
  assign s1_ready  = !s1_valid_q || s1_adv;
  assign s2_load   = s1_adv && !s1_nores;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Stage 0: position, flags, line store read
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0]          px;
  logic [PIXEL_BITS+PixPortW-1:0] px_ext;
  logic                           col_end, row_end, has_up, interior;
  logic [ColW-1:0]                col_next;

  assign px_ext   = {{PIXEL_BITS{1'b0}}, pixel_i};
  assign px       = px_ext[PIXEL_BITS-1:0];
  assign col_end  = (col_q == last_col_q);
  assign row_end  = (row_q == last_row_q);
  assign has_up   = (row_q != '0);
  assign interior = (row_q[RowW-1:1] != '0) && (col_q != '0) && !col_end;
  // Right neighbour address; the end column has no right neighbour.
  assign col_next = col_end ? '0 : col_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LastColRst;
      last_row_q <= LastRowRst;
      col_q      <= '0;
      row_q      <= '0;
    end else if (cfg_we) begin
      // Any register write restarts the frame.
      col_q <= '0;
      row_q <= '0;
      case (cfg_reg_e'(cfg_index_i))
        RegFrameWidth:  last_col_q <= last_col_cfg;
        RegFrameHeight: last_row_q <= last_row_cfg;
        default: ;
      endcase
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores
  // ---------------------------------------------------------------------------
  ls_ctrl_t              ls_ctrl;
  logic [PIXEL_BITS-1:0] centre, right, up;
  logic [ColW-1:0]       s1_col_q;

  assign ls_ctrl.rd_en    = in_acc;
  assign ls_ctrl.wr_above = in_acc;
  assign ls_ctrl.wr_two   = s1_adv;

  fnpm_line_store #(
    .Depth   (MAX_WIDTH),
    .PixBits (PIXEL_BITS),
    .AddrW   (ColW)
  ) u_line_store (
    .clk_i      (clk_i),
    .ctrl_i     (ls_ctrl),
    .col_i      (col_q),
    .col_next_i (col_next),
    .pix_i      (px),
    .two_addr_i (s1_col_q),
    .two_data_i (centre),
    .centre_o   (centre),
    .right_o    (right),
    .up_o       (up)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: compare against the four neighbours
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]       s1_row_q;
  logic [PIXEL_BITS-1:0] s1_px_q, left_q;
  logic                  s1_interior_q, peak;

  // Left neighbour is the previous pixel's centre, valid whenever the column
  // is not zero (a register write always restarts at column zero).
  assign peak = s1_interior_q && (centre > up) && (centre > s1_px_q)
                && (centre > left_q) && (centre > right);

  // ---------------------------------------------------------------------------
  // Stage 2: hold one or two words for the output register
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]       s2_row_q;
  logic [ColW-1:0]       s2_col_q;
  logic [PIXEL_BITS-1:0] s2_centre_q, s2_px_q;
  logic                  s2_peak_q;
  logic                  s2_first;
  logic [RowW-1:0]       w_row;
  logic [PIXEL_BITS-1:0] w_val;
  logic                  w_peak, w_last;

  assign s2_first = s2_has_up_q && !s2_second_q;

  always_comb begin
    if (s2_first) begin
      w_row  = s2_row_q - 1'b1;
      w_val  = s2_centre_q;
      w_peak = s2_peak_q;
      w_last = !s2_last_row_q;
    end else begin
      w_row  = s2_row_q;
      w_val  = s2_px_q;
      w_peak = 1'b0;
      w_last = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and word sequencing
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_second_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_acc;
      end
      if (s2_ready) begin
        s2_valid_q <= s2_load;
      end
      if (s2_load) begin
        s2_second_q <= 1'b0;
      end else if (s3_load) begin
        s2_second_q <= !s2_final;
      end
      if (s3_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]                 out_row_q;
  logic [ColW-1:0]                 out_colw_q;
  logic [PIXEL_BITS-1:0]           out_val_q;
  logic                            out_peak_q, out_last_q;
  logic [ColW+OutColW-1:0]         col_ext;
  logic [PIXEL_BITS+PixPortW-1:0]  val_ext;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_px_q       <= px;
      s1_has_up_q   <= has_up;
      s1_last_row_q <= row_end;
      s1_interior_q <= interior;
    end
    if (s1_adv) begin
      left_q <= centre;
    end
    if (s2_load) begin
      s2_row_q      <= s1_row_q;
      s2_col_q      <= s1_col_q;
      s2_centre_q   <= centre;
      s2_px_q       <= s1_px_q;
      s2_peak_q     <= peak;
      s2_has_up_q   <= s1_has_up_q;
      s2_last_row_q <= s1_last_row_q;
    end
    if (s3_load) begin
      out_row_q  <= w_row;
      out_colw_q <= s2_col_q;
      out_val_q  <= w_val;
      out_peak_q <= w_peak;
      out_last_q <= w_last;
    end
  end

  // Fit the internal column and pixel widths to the fixed port widths.
  assign col_ext = {{OutColW{1'b0}}, out_colw_q};
  assign val_ext = {{PixPortW{1'b0}}, out_val_q};

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = col_ext[OutColW-1:0];
  assign value_o     = val_ext[PixPortW-1:0];
  assign is_peak_o   = out_peak_q;
  assign last_o      = out_last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_peak_not_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_peak_o |-> (out_row_o != '0) && (out_col_o != '0))
    else $error("peak flagged on a border pixel");

  a_second_word_only_for_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_second_q |-> s2_valid_q && s2_has_up_q && s2_last_row_q)
    else $error("second word pending for a single-word item");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col_q)
    else $error("column counter beyond frame width");

  a_empty_stage_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  a_pair_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_load && !s2_final |=> s2_valid_q && s2_second_q)
    else $error("second word of a last-row pixel lost");

endmodule
